// File: rtl/b64s_pkg.sv
// Shared types, codes and signature tables for the base64 decoder with image sniffing.
`timescale 1ns / 1ps

package b64s_pkg;

   // Number of header bytes kept per stream (default for the top-level parameter)
   localparam int HEADER_BYTES_DEF = 8;

   // Result queue depth and index widths
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Accumulator geometry
   localparam int ACC_W     = 12;
   localparam int PEND_W    = 3;
   localparam int SEXTET_W  = 6;

   // Result item kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Image format codes
   typedef enum logic [1:0] {
      FMT_PNG  = 2'd0,
      FMT_GIF  = 2'd1,
      FMT_BMP  = 2'd2,
      FMT_JPEG = 2'd3
   } fmt_type;

   // Signature table, checked in order; the first hit wins
   localparam int SIG_COUNT = 10;
   localparam int SIG_MAX   = 8;

   localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{
      4'd8, 4'd6, 4'd6, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
   };

   localparam fmt_type SIG_FMT [SIG_COUNT] = '{
      FMT_PNG, FMT_GIF, FMT_GIF, FMT_BMP,
      FMT_JPEG, FMT_JPEG, FMT_JPEG, FMT_JPEG, FMT_JPEG, FMT_JPEG
   };

   localparam logic [7:0] SIG_BYTES [SIG_COUNT][SIG_MAX] = '{
      '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
      '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hE2, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hE8, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // One result item as held in the result queue
   typedef struct packed {
      logic       item_kind;
      logic [7:0] out_byte;
      fmt_type    image_format;
      logic       last_item;
   } rsp_item_type;

   // Base64 character decode: bit 6 flags a character of the alphabet
   function automatic logic [SEXTET_W:0] sextet_of(input logic [7:0] ch);
      logic [SEXTET_W:0] res;
      res = '0;
      case (ch) inside
         [8'h41:8'h5A]: res = {1'b1, 6'(ch - 8'h41)};          // A-Z
         [8'h61:8'h7A]: res = {1'b1, 6'(ch - 8'h61 + 8'd26)};  // a-z
         [8'h30:8'h39]: res = {1'b1, 6'(ch - 8'h30 + 8'd52)};  // 0-9
         8'h2B:         res = {1'b1, 6'd62};                   // plus
         8'h2F:         res = {1'b1, 6'd63};                   // slash
         default:       res = '0;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/b64s_req_if.sv
// Input channel: one character or raw byte per item.
`timescale 1ns / 1ps

interface b64s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/b64s_rsp_if.sv
// Result channel: decoded data bytes and the closing format report.
`timescale 1ns / 1ps

interface b64s_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] out_byte;
   logic [1:0] image_format;
   logic       last_item;

   modport source (output valid, output item_kind, output out_byte, output image_format,
                   output last_item, input ready);
   modport sink   (input valid, input item_kind, input out_byte, input image_format,
                   input last_item, output ready);
endinterface

// File: rtl/base64_decode_image_sniff_core.sv
// Base64 / raw byte stream decoder with header capture and image format sniffing.
// An accepted item is held in the input register and decoded from there; its results go to the queue and show on rsp.
// Throughput: one item per cycle while the queue has room; a final item with a data byte queues two results.
// Input ready follows a four-entry result queue, which takes an item while two slots are free.
// Reset (synchronous, active high) empties the queue and input register, clears the
// accumulator and header count, and selects base64 mode.
`timescale 1ns / 1ps

module base64_decode_image_sniff_core #(
   parameter int HEADER_BYTES = b64s_pkg::HEADER_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   b64s_req_if.sink     req_ch,
   b64s_rsp_if.source   rsp_ch,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   localparam int HDR_CNT_W = $clog2(HEADER_BYTES + 1);
   localparam int HDR_IDX_W = $clog2(HEADER_BYTES);

   // Mode register
   logic mode_ff;

   // Input register
   logic       stg_valid_ff;
   logic [7:0] stg_char_ff;
   logic       stg_last_ff;

   // Stream state
   logic [b64s_pkg::ACC_W-1:0]  acc_ff,  acc_in;
   logic [b64s_pkg::PEND_W-1:0] pend_ff, pend_in;
   logic [7:0]                  hdr_ff [HEADER_BYTES];
   logic [HDR_CNT_W-1:0]        hdr_cnt_ff, hdr_cnt_in;

   // Result queue
   b64s_pkg::rsp_item_type        rq_ff [b64s_pkg::RSP_DEPTH];
   logic [b64s_pkg::RSP_PTR_W-1:0] rd_ptr_ff, wr_ptr_ff;
   logic [b64s_pkg::RSP_CNT_W-1:0] rq_cnt_ff;

   logic rq_room;
   logic process;
   logic pop;

   // Decode signals
   logic [b64s_pkg::SEXTET_W:0]   sx;
   logic [b64s_pkg::ACC_W-1:0]    acc_shift;
   logic [b64s_pkg::PEND_W:0]     pend_sum;
   logic [b64s_pkg::PEND_W-1:0]   pend_left;
   logic                          have_byte;
   logic [7:0]                    byte_val;
   logic                          keep;
   logic [7:0]                    hdr_view [HEADER_BYTES];
   logic [HDR_CNT_W-1:0]          cnt_view;
   logic [b64s_pkg::SIG_COUNT-1:0] sig_hit;
   b64s_pkg::fmt_type             fmt;

   b64s_pkg::rsp_item_type data_item, rpt_item;
   b64s_pkg::rsp_item_type push0, push1;
   logic [1:0]             push_n;

   // Take a new item while the input register empties this cycle
   assign rq_room      = rq_cnt_ff <= b64s_pkg::RSP_CNT_W'(b64s_pkg::RSP_DEPTH - 2);
   assign process      = stg_valid_ff && rq_room;
   assign req_ch.ready = !stg_valid_ff || rq_room;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   // Decode one character against the current accumulator
   always_comb begin
      sx        = b64s_pkg::sextet_of(stg_char_ff);
      acc_shift = {acc_ff[b64s_pkg::ACC_W-b64s_pkg::SEXTET_W-1:0],
                   sx[b64s_pkg::SEXTET_W-1:0]};
      pend_sum  = {1'b0, pend_ff} + (b64s_pkg::PEND_W+1)'(b64s_pkg::SEXTET_W);
      pend_left = b64s_pkg::PEND_W'(pend_sum - (b64s_pkg::PEND_W+1)'(8));
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      have_byte = 1'b0;
      byte_val  = stg_char_ff;
      if (mode_ff) begin
         if (sx[b64s_pkg::SEXTET_W]) begin
            acc_in = acc_shift;
            if (pend_sum >= (b64s_pkg::PEND_W+1)'(8)) begin
               pend_in   = pend_left;
               have_byte = 1'b1;
               byte_val  = 8'(acc_shift >> pend_left);
            end else begin
               pend_in = b64s_pkg::PEND_W'(pend_sum);
            end
         end
      end else begin
         have_byte = 1'b1;
      end
      // End of stream drops leftover bits
      if (stg_last_ff) begin
         acc_in  = '0;
         pend_in = '0;
      end
   end

   // Header view including the byte stored this cycle
   assign keep = have_byte && (hdr_cnt_ff < HDR_CNT_W'(HEADER_BYTES));

   always_comb begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
         hdr_view[i] = (keep && hdr_cnt_ff == HDR_CNT_W'(i)) ? byte_val : hdr_ff[i];
      end
      cnt_view   = hdr_cnt_ff + HDR_CNT_W'(keep);
      hdr_cnt_in = stg_last_ff ? '0 : cnt_view;
   end

   // Match each signature, then take the first hit in table order
   always_comb begin
      for (int s = 0; s < b64s_pkg::SIG_COUNT; s++) begin
         sig_hit[s] = cnt_view >= HDR_CNT_W'(b64s_pkg::SIG_LEN[s]);
         for (int i = 0; i < b64s_pkg::SIG_MAX; i++) begin
            if (i < int'(b64s_pkg::SIG_LEN[s]) && hdr_view[i] != b64s_pkg::SIG_BYTES[s][i]) begin
               sig_hit[s] = 1'b0;
            end
         end
      end
      fmt = b64s_pkg::FMT_JPEG;
      for (int s = b64s_pkg::SIG_COUNT - 1; s >= 0; s--) begin
         if (sig_hit[s]) begin
            fmt = b64s_pkg::SIG_FMT[s];
         end
      end
   end

   // Build the results of this item
   always_comb begin
      data_item.item_kind    = b64s_pkg::KIND_DATA;
      data_item.out_byte     = byte_val;
      data_item.image_format = b64s_pkg::FMT_PNG;
      data_item.last_item    = 1'b0;
      rpt_item.item_kind     = b64s_pkg::KIND_REPORT;
      rpt_item.out_byte      = 8'h00;
      rpt_item.image_format  = fmt;
      rpt_item.last_item     = 1'b1;
      push0  = have_byte ? data_item : rpt_item;
      push1  = rpt_item;
      push_n = 2'(have_byte) + 2'(stg_last_ff);
      if (!process) begin
         push_n = 2'd0;
      end
   end

   // Drive the result channel from the queue head
   assign rsp_ch.valid        = rq_cnt_ff != '0;
   assign rsp_ch.item_kind    = rq_ff[rd_ptr_ff].item_kind;
   assign rsp_ch.out_byte     = rq_ff[rd_ptr_ff].out_byte;
   assign rsp_ch.image_format = rq_ff[rd_ptr_ff].image_format;
   assign rsp_ch.last_item    = rq_ff[rd_ptr_ff].last_item;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         stg_valid_ff <= 1'b0;
         acc_ff       <= '0;
         pend_ff      <= '0;
         hdr_cnt_ff   <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         rq_cnt_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (req_ch.ready) begin
            stg_valid_ff <= req_ch.valid;
         end
         if (process) begin
            acc_ff     <= acc_in;
            pend_ff    <= pend_in;
            hdr_cnt_ff <= hdr_cnt_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         wr_ptr_ff <= wr_ptr_ff + b64s_pkg::RSP_PTR_W'(push_n);
         rq_cnt_ff <= rq_cnt_ff + b64s_pkg::RSP_CNT_W'(push_n)
                      - b64s_pkg::RSP_CNT_W'(pop);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         stg_char_ff <= req_ch.char_code;
         stg_last_ff <= req_ch.last_char;
      end
      if (process && keep) begin
         hdr_ff[hdr_cnt_ff[HDR_IDX_W-1:0]] <= byte_val;
      end
      if (push_n != 2'd0) begin
         rq_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         rq_ff[wr_ptr_ff + 1'b1] <= push1;
      end
   end

`ifndef SYNTHESIS
   // Queue never overfills
   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= b64s_pkg::RSP_CNT_W'(b64s_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // Six-bit steps minus eight keep the pending count even
   a_pend_even: assert property (@(posedge clock) disable iff (reset)
      !pend_ff[0])
      else $error("odd pending bit count");

   // A final item restarts the stream
   a_stream_restart: assert property (@(posedge clock) disable iff (reset)
      process && stg_last_ff |=> hdr_cnt_ff == '0 && pend_ff == '0 && acc_ff == '0)
      else $error("stream state not cleared after final item");

   // A held item with no queue room blocks the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !rq_room |-> !req_ch.ready)
      else $error("input accepted while queue lacks room");

   // Each processed final item pushes exactly one report as its last result; checked as a non-empty queue
   a_report_push: assert property (@(posedge clock) disable iff (reset)
      process && stg_last_ff |=> rq_cnt_ff != '0)
      else $error("report not queued");
`endif

endmodule
